// ===== design/stereo_bit_packer_top_macros.svh =====
// assertion macros for the stereo bit packer top level
// expects i_clk and i_rst_n in the including scope
`ifndef STEREO_BIT_PACKER_TOP_MACROS_SVH
`define STEREO_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBP_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SBP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sbp_pkg.sv =====
// shared types, constants and helpers of the stereo bit packer
// no dependencies
`default_nettype none

package sbp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PAIR_BITS = 2 * SAMPLE_W;
    localparam int KEEP_W    = 5;
    localparam int OUT_W     = 16;
    localparam int CFG_DW    = 32;
    localparam int CFG_AW    = 3;

    typedef logic [KEEP_W-1:0]   t_keep;
    typedef logic [SAMPLE_W-1:0] t_sample;

    // register index, taken from paddr above the byte offset
    typedef enum logic [0:0] {
        REG_SAMPLE_BITS = 1'b0
    } t_reg_idx;

    // pair of lane results handed to the packer
    typedef struct packed {
        t_sample left_bits;
        t_sample right_bits;
        t_keep   keep;
        logic    last;
    } t_pair;

    // out-of-range widths fold to the nearest legal value
    function automatic t_keep clamp_keep(input t_keep v);
        t_keep r;
        if (v == '0) begin
            r = t_keep'(1);
        end else if (v > t_keep'(SAMPLE_W)) begin
            r = t_keep'(SAMPLE_W);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sbp_lane.sv =====
// one sample lane: keeps the top bits of a sample, right aligned
// uses sbp_pkg
`default_nettype none

module sbp_lane
    import sbp_pkg::*;
(
    input  wire t_sample i_sample,
    input  wire t_keep   i_keep,
    output t_sample      o_bits
);

    t_keep drop;

    assign drop   = t_keep'(SAMPLE_W) - i_keep;
    assign o_bits = i_sample >> drop;

endmodule

`default_nettype wire

// ===== design/sbp_pack.sv =====
// merge of the two lanes, bit accumulator and output word register
// uses sbp_pkg
`default_nettype none

module sbp_pack
    import sbp_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int ACC_W     = WORD_BITS + PAIR_BITS,
    parameter int CNT_W     = $clog2(ACC_W)
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_pair       i_pair,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic [OUT_W-1:0] o_packed_word,
    output logic             o_last_word,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic [CNT_W-1:0] o_fill,
    output logic             o_flushing
);

    localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WORD_BITS);

    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_flush, n_flush;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_word;
    logic                 r_out_last;

    logic [PAIR_BITS-1:0] merged;
    logic [PAIR_BITS-1:0] aligned;
    logic [5:0]           nbits;
    logic [ACC_W-1:0]     placed;
    logic [ACC_W-1:0]     acc_sh;
    logic [CNT_W-1:0]     cnt_sh;
    logic                 flush_sh;
    logic                 emit;
    logic                 emit_fire;
    logic                 take;
    logic [WORD_BITS-1:0] word;

    // merge: left bits ahead of right bits, then MSB aligned
    assign merged  = ({{SAMPLE_W{1'b0}}, i_pair.left_bits} << i_pair.keep)
                   | {{SAMPLE_W{1'b0}}, i_pair.right_bits};
    assign nbits   = {i_pair.keep, 1'b0};
    assign aligned = merged << (6'(PAIR_BITS) - nbits);

    // a word leaves when full, or when the stream end is being flushed
    assign emit      = r_flush ? (r_cnt != '0) : (r_cnt >= WORD_CNT);
    assign emit_fire = emit && (!r_out_valid || !i_out_stall);
    assign word      = r_acc[ACC_W-1 -: WORD_BITS];

    always_comb begin
        if (emit_fire) begin
            acc_sh = r_acc << WORD_BITS;
            cnt_sh = (r_cnt >= WORD_CNT) ? (r_cnt - WORD_CNT) : '0;
        end else begin
            acc_sh = r_acc;
            cnt_sh = r_cnt;
        end
    end

    assign flush_sh   = r_flush && (cnt_sh != '0);
    assign o_in_stall = flush_sh || (cnt_sh >= WORD_CNT);
    assign take       = i_in_valid && !o_in_stall;
    assign placed     = {aligned, {WORD_BITS{1'b0}}} >> cnt_sh;

    always_comb begin
        n_acc   = acc_sh;
        n_cnt   = cnt_sh;
        n_flush = flush_sh;
        if (take) begin
            n_acc   = acc_sh | placed;
            n_cnt   = cnt_sh + CNT_W'(nbits);
            n_flush = i_pair.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_word <= OUT_W'(word);
            r_out_last <= r_flush && (r_cnt <= WORD_CNT);
        end
    end

    assign o_packed_word = r_out_word;
    assign o_last_word   = r_out_last;
    assign o_out_valid   = r_out_valid;
    assign o_fill        = r_cnt;
    assign o_flushing    = r_flush;

endmodule

`default_nettype wire

// ===== design/stereo_bit_packer_top.sv =====
// stereo bit packer top level: register port, two sample lanes, packer
// uses sbp_pkg, sbp_lane, sbp_pack and stereo_bit_packer_top_macros.svh
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-----------------------------------
//  in      | in  | i_in_valid / o_in_stall    | i_left_sample i_right_sample
//          |     |                            | i_last_pair
//  out     | out | o_out_valid / i_out_stall  | o_packed_word o_last_word
//  cfg     | in  | psel penable pwrite pready | paddr pwdata prdata
//
// a pair is taken once fewer than a word of bits is left behind the outgoing word,
// so a new pair can merge in while earlier bits are still being sent out;
// the output register moves one word per cycle while i_out_stall is low
// a last pair holds off the next pair until its padded word is loaded out
// reset (synchronous, active low) empties the accumulator and sets sample_bits to 16
// a stalled output word holds; the next pair still merges behind it
`default_nettype none
`include "stereo_bit_packer_top_macros.svh"

module stereo_bit_packer_top
    import sbp_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // pair input
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [SAMPLE_W-1:0] i_left_sample,
    input  wire  [SAMPLE_W-1:0] i_right_sample,
    input  wire                i_last_pair,
    // word output
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [OUT_W-1:0]   o_packed_word,
    output logic               o_last_word,
    // register port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [CFG_AW-1:0]  paddr,
    input  wire  [CFG_DW-1:0]  pwdata,
    output logic [CFG_DW-1:0]  prdata,
    output logic               pready
);

    localparam int ACC_W = WORD_BITS + PAIR_BITS;
    localparam int CNT_W = $clog2(ACC_W);

    t_keep            r_sample_bits;
    t_keep            keep;
    t_reg_idx         reg_idx;
    logic             cfg_write;
    t_sample          left_bits;
    t_sample          right_bits;
    t_pair            pair;
    logic [CNT_W-1:0] fill;
    logic             flushing;

    // register port: single register at byte offset zero, no wait states
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[CFG_AW-1]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits <= t_keep'(SAMPLE_W);
        end else if (cfg_write && (reg_idx == REG_SAMPLE_BITS)) begin
            r_sample_bits <= pwdata[KEEP_W-1:0];
        end
    end

    // unused address bits below the word offset read as the same register
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_SAMPLE_BITS) begin
            prdata = CFG_DW'(r_sample_bits);
        end
    end

    // width actually kept per sample, zero and oversize values folded in
    assign keep = clamp_keep(r_sample_bits);

    // one lane per channel, both trim in the same cycle
    sbp_lane u_lane_left (
        .i_sample (i_left_sample),
        .i_keep   (keep),
        .o_bits   (left_bits)
    );

    sbp_lane u_lane_right (
        .i_sample (i_right_sample),
        .i_keep   (keep),
        .o_bits   (right_bits)
    );

    assign pair.left_bits  = left_bits;
    assign pair.right_bits = right_bits;
    assign pair.keep       = keep;
    assign pair.last       = i_last_pair;

    // merge of both lanes into the stream and word output
    sbp_pack #(
        .WORD_BITS (WORD_BITS)
    ) u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pair        (pair),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .o_packed_word (o_packed_word),
        .o_last_word   (o_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_fill        (fill),
        .o_flushing    (flushing)
    );

    // a pending flush always has bits left to send
    `SBP_CHECK_NOW(a_flush_has_bits, flushing, fill != '0, "flush pending with no bits")
    // fewer than a word of leftover bits and no flush must never hold off a pair
    `SBP_CHECK_NOW(a_no_needless_stall, !flushing && (fill < CNT_W'(WORD_BITS)), !o_in_stall, "pair stalled with room")
    // the accumulator never overflows its storage
    `SBP_CHECK_NOW(a_fill_bound, 1'b1, fill < CNT_W'(ACC_W), "accumulator overflow")
    // after the final word of a stream leaves, any pending flush still has bits to send
    `SBP_CHECK_NEXT(a_last_clears, o_out_valid && o_last_word && !i_out_stall && !$past(flushing), !flushing || (fill != '0), "stream end left state behind")

endmodule

`default_nettype wire
